### rtl/gdu_pkg.sv
// Shared types, constants and calendar helper functions of the Gregorian date unit.
package gdu_pkg;

	// Calendar limits and reset date.
	localparam int MIN_YEAR    = 1900;
	localparam int MAX_YEAR    = 9999;
	localparam int RESET_DAY   = 1;
	localparam int RESET_MONTH = 1;
	localparam int RESET_YEAR  = 2000;
	localparam int YEAR_CYCLE  = 400;
	localparam int RESET_YRES  = RESET_YEAR % YEAR_CYCLE;

	// Field widths.
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int ADD_W   = 16;
	localparam int WDAY_W  = 3;
	localparam int ACC_W   = ADD_W + 1;
	localparam int YRES_W  = 9;
	localparam int SUM_W   = 15;

	// Month codes that the logic refers to.
	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	// Reciprocal constants for division by 25 and by 7.
	localparam int DIV25_MUL = 1311;
	localparam int DIV7_MUL  = 37450;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SET_MY,
		ST_SET_Q,
		ST_SET_R,
		ST_SET_D,
		ST_WALK,
		ST_WK1,
		ST_WK2,
		ST_WK3,
		ST_WK4,
		ST_OUT
	} gdu_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic set_my;
		logic set_q;
		logic set_res;
		logic set_day;
		logic walk;
		logic wk1;
		logic wk2;
		logic wk3;
		logic wk4;
		logic load_out;
	} gdu_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic op_add;
		logic walk_last;
	} gdu_stat_t;

	// Leap year test on the year taken modulo 400.
	function automatic logic is_leap_res(input logic [YRES_W-1:0] r);
		return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	// Length of a month; February follows the leap flag.
	function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// Month term floor(31 * mm / 12) of the weekday formula, mm counted from March.
	function automatic logic [DAY_W-1:0] month_term(input logic [MONTH_W-1:0] mm);
		logic [DAY_W-1:0] t;
		unique case (mm)
			4'd1:    t = 5'd2;
			4'd2:    t = 5'd5;
			4'd3:    t = 5'd7;
			4'd4:    t = 5'd10;
			4'd5:    t = 5'd12;
			4'd6:    t = 5'd15;
			4'd7:    t = 5'd18;
			4'd8:    t = 5'd20;
			4'd9:    t = 5'd23;
			4'd10:   t = 5'd25;
			4'd11:   t = 5'd28;
			4'd12:   t = 5'd31;
			default: t = 5'd0;
		endcase
		return t;
	endfunction

	// Exact division by 25 of a 12-bit value through a reciprocal multiply.
	function automatic logic [7:0] div25(input logic [11:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'(DIV25_MUL);
		return p[22:15];
	endfunction

endpackage

### rtl/gdu_ctrl.sv
// Controller state machine of the Gregorian date unit.
module gdu_ctrl import gdu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  gdu_stat_t stat,
	output gdu_cmd_t  cmd
);

	gdu_state_t state_q, state_nxt;
	logic       out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Result valid flag: set when the output register loads, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = stat.op_add ? ST_WALK : ST_SET_MY;
				end
			end
			ST_SET_MY: state_nxt = ST_SET_Q;
			ST_SET_Q:  state_nxt = ST_SET_R;
			ST_SET_R:  state_nxt = ST_SET_D;
			ST_SET_D:  state_nxt = ST_WK1;
			ST_WALK: begin
				if (stat.walk_last) begin
					state_nxt = ST_WK1;
				end
			end
			ST_WK1: state_nxt = ST_WK2;
			ST_WK2: state_nxt = ST_WK3;
			ST_WK3: state_nxt = ST_WK4;
			ST_WK4: state_nxt = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Commands and handshake outputs.
	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_SET_MY: cmd.set_my  = 1'b1;
			ST_SET_Q:  cmd.set_q   = 1'b1;
			ST_SET_R:  cmd.set_res = 1'b1;
			ST_SET_D:  cmd.set_day = 1'b1;
			ST_WALK:   cmd.walk    = 1'b1;
			ST_WK1:    cmd.wk1     = 1'b1;
			ST_WK2:    cmd.wk2     = 1'b1;
			ST_WK3:    cmd.wk3     = 1'b1;
			ST_WK4:    cmd.wk4     = 1'b1;
			ST_OUT:    cmd.load_out = !out_valid_q || out_ready;
			default:   cmd = '0;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/gdu_dpath.sv
// Datapath of the Gregorian date unit: stored date, month walk, weekday and result register.
module gdu_dpath import gdu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  gdu_cmd_t           cmd,
	output gdu_stat_t          stat,
	input  logic               opcode,
	input  logic [DAY_W-1:0]   new_day,
	input  logic [MONTH_W-1:0] new_month,
	input  logic [YEAR_W-1:0]  new_year,
	input  logic [ADD_W-1:0]   days_to_add,
	output logic [DAY_W-1:0]   cur_day,
	output logic [MONTH_W-1:0] cur_month,
	output logic [YEAR_W-1:0]  cur_year,
	output logic [WDAY_W-1:0]  weekday,
	output logic               day_rejected,
	output logic               month_rejected,
	output logic               year_rejected,
	output logic               overflow
);

	// Stored date and year residue modulo 400.
	logic [DAY_W-1:0]   day_q;
	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;
	logic [YRES_W-1:0]  yres_q;

	// Captured request and working values.
	logic [DAY_W-1:0]   nday_q;
	logic [MONTH_W-1:0] nmonth_q;
	logic [YEAR_W-1:0]  nyear_q;
	logic [ACC_W-1:0]   acc_q;
	logic [5:0]         qcyc_q;
	logic               drej_q, mrej_q, yrej_q, ovf_q;

	// Weekday sequence registers.
	logic [YEAR_W-1:0]  yy_q;
	logic [DAY_W-1:0]   mterm_q;
	logic [7:0]         q100_q;
	logic [5:0]         q400_q;
	logic [SUM_W-1:0]   sum_q;
	logic [11:0]        q7_q;

	// Result register.
	logic [DAY_W-1:0]   res_day_q;
	logic [MONTH_W-1:0] res_month_q;
	logic [YEAR_W-1:0]  res_year_q;
	logic [WDAY_W-1:0]  res_wday_q;
	logic               res_drej_q, res_mrej_q, res_yrej_q, res_ovf_q;

	// Combinational helpers.
	logic               leap;
	logic [DAY_W-1:0]   len;
	logic               fits;
	logic               at_last_month;
	logic               month_ok, year_ok, day_ok;
	logic [YEAR_W-1:0]  cyc_base;
	logic [7:0]         qcyc_full;
	logic [7:0]         q400_full;
	logic               early;
	logic [MONTH_W-1:0] mm;
	logic [15:0]        sum_w;
	logic [30:0]        prod7;
	logic [SUM_W-1:0]   rem_w;

	// Month length of the current month, the walk decisions, the request checks and the 400-year cycle base.
	always_comb begin
		leap          = is_leap_res(yres_q);
		len           = month_length(month_q, leap);
		fits          = acc_q <= ACC_W'(len);
		at_last_month = (month_q == MON_DEC) && (year_q == YEAR_W'(MAX_YEAR));
		month_ok      = (nmonth_q >= MON_JAN) && (nmonth_q <= MON_DEC);
		year_ok       = (nyear_q >= YEAR_W'(MIN_YEAR)) && (nyear_q <= YEAR_W'(MAX_YEAR));
		day_ok        = (nday_q != '0) && (nday_q <= len);
		qcyc_full     = div25({2'b00, year_q[YEAR_W-1:4]});
		cyc_base      = YEAR_W'(qcyc_q) * YEAR_W'(YEAR_CYCLE);
	end

	assign stat.op_add    = opcode;
	assign stat.walk_last = fits || at_last_month;

	// Stored date and residue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q   <= DAY_W'(RESET_DAY);
			month_q <= MONTH_W'(RESET_MONTH);
			year_q  <= YEAR_W'(RESET_YEAR);
			yres_q  <= YRES_W'(RESET_YRES);
		end else begin
			if (cmd.set_my) begin
				if (month_ok) begin
					month_q <= nmonth_q;
				end
				if (year_ok) begin
					year_q <= nyear_q;
				end
			end
			if (cmd.set_res) begin
				yres_q <= YRES_W'(year_q - cyc_base);
			end
			if (cmd.set_day && day_ok) begin
				day_q <= nday_q;
			end
			if (cmd.walk) begin
				priority if (fits) begin
					day_q <= acc_q[DAY_W-1:0];
				end else if (at_last_month) begin
					day_q <= DAY_W'(31);
				end else if (month_q == MON_DEC) begin
					month_q <= MON_JAN;
					year_q  <= year_q + 1'b1;
					yres_q  <= (yres_q == YRES_W'(YEAR_CYCLE - 1)) ? '0 : yres_q + 1'b1;
				end else begin
					month_q <= month_q + 1'b1;
				end
			end
		end
	end

	// Request capture, walk accumulator, 400-year cycle count, reject flags and overflow flag.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			nday_q   <= new_day;
			nmonth_q <= new_month;
			nyear_q  <= new_year;
			acc_q    <= ACC_W'(day_q) + ACC_W'(days_to_add);
			drej_q   <= 1'b0;
			mrej_q   <= 1'b0;
			yrej_q   <= 1'b0;
			ovf_q    <= 1'b0;
		end
		if (cmd.set_my) begin
			mrej_q <= !month_ok;
			yrej_q <= !year_ok;
		end
		if (cmd.set_q) begin
			qcyc_q <= qcyc_full[5:0];
		end
		if (cmd.set_day) begin
			drej_q <= !day_ok;
		end
		if (cmd.walk && !fits) begin
			if (at_last_month) begin
				ovf_q <= 1'b1;
			end else begin
				acc_q <= acc_q - ACC_W'(len);
			end
		end
	end

	// Weekday: shifted year, month term, century terms, sum and modulo 7.
	always_comb begin
		early     = month_q <= MON_FEB;
		mm        = early ? month_q + 4'd10 : month_q - 4'd2;
		q400_full = div25({2'b00, yy_q[YEAR_W-1:4]});
		sum_w     = 16'(day_q) + 16'(yy_q) + 16'(yy_q[YEAR_W-1:2]) - 16'(q100_q)
		          + 16'(q400_q) + 16'(mterm_q);
		prod7     = 31'(sum_q) * 31'(DIV7_MUL);
		rem_w     = sum_q - {q7_q, 3'b000} + SUM_W'(q7_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.wk1) begin
			yy_q    <= year_q - YEAR_W'(early);
			mterm_q <= month_term(mm);
		end
		if (cmd.wk2) begin
			q100_q <= div25(yy_q[YEAR_W-1:2]);
			q400_q <= q400_full[5:0];
		end
		if (cmd.wk3) begin
			sum_q <= sum_w[SUM_W-1:0];
		end
		if (cmd.wk4) begin
			q7_q <= prod7[29:18];
		end
	end

	// Result register, held until the result is taken.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_day_q   <= day_q;
			res_month_q <= month_q;
			res_year_q  <= year_q;
			res_wday_q  <= rem_w[WDAY_W-1:0];
			res_drej_q  <= drej_q;
			res_mrej_q  <= mrej_q;
			res_yrej_q  <= yrej_q;
			res_ovf_q   <= ovf_q;
		end
	end

	assign cur_day        = res_day_q;
	assign cur_month      = res_month_q;
	assign cur_year       = res_year_q;
	assign weekday        = res_wday_q;
	assign day_rejected   = res_drej_q;
	assign month_rejected = res_mrej_q;
	assign year_rejected  = res_yrej_q;
	assign overflow       = res_ovf_q;

endmodule

### rtl/gregorian_date_unit.sv
// Gregorian date unit, top level: a controller and a datapath.
//
// The unit keeps one date, reset to 1/1/2000, and handles one request at a time.
// A set request validates month, year and then day, and its result is loaded once
// the weekday is worked out. An add request walks the date one month per cycle in
// the datapath, crossing up to about 2160 month boundaries for the largest day
// count; the walk stops at 31/12/9999 and flags overflow. The weekday comes from
// a short multiply sequence after each update. The next request is taken in the
// cycle after a result is loaded. The result sits in an output register, so it may
// wait to be taken while the next request is already being worked on; that next
// result is held back until the waiting one has gone.
module gregorian_date_unit import gdu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [DAY_W-1:0]   new_day,
	input  logic [MONTH_W-1:0] new_month,
	input  logic [YEAR_W-1:0]  new_year,
	input  logic [ADD_W-1:0]   days_to_add,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DAY_W-1:0]   cur_day,
	output logic [MONTH_W-1:0] cur_month,
	output logic [YEAR_W-1:0]  cur_year,
	output logic [WDAY_W-1:0]  weekday,
	output logic               day_rejected,
	output logic               month_rejected,
	output logic               year_rejected,
	output logic               overflow
);

	gdu_cmd_t  cmd;
	gdu_stat_t stat;

	// Sequencing of the request phases.
	gdu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Date storage and arithmetic.
	gdu_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.opcode         (opcode),
		.new_day        (new_day),
		.new_month      (new_month),
		.new_year       (new_year),
		.days_to_add    (days_to_add),
		.cur_day        (cur_day),
		.cur_month      (cur_month),
		.cur_year       (cur_year),
		.weekday        (weekday),
		.day_rejected   (day_rejected),
		.month_rejected (month_rejected),
		.year_rejected  (year_rejected),
		.overflow       (overflow)
	);

endmodule

### rtl/gdu_checker.sv
// Port-level checks of the Gregorian date unit and their binding to the top level.
module gdu_checker import gdu_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [DAY_W-1:0]   cur_day,
	input logic [MONTH_W-1:0] cur_month,
	input logic [YEAR_W-1:0]  cur_year,
	input logic [WDAY_W-1:0]  weekday,
	input logic               day_rejected,
	input logic               month_rejected,
	input logic               year_rejected,
	input logic               overflow
);

	// An accepted request keeps the unit busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("unit ready again straight after accepting a request");

	// A result that waits stays valid and holds its day and year.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(cur_day) && $stable(cur_year)))
		else $error("waiting result changed or was dropped");

	// Every result shows a real month and weekday.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cur_month >= MON_JAN && cur_month <= MON_DEC && weekday <= 3'd6))
		else $error("result month or weekday out of range");

	// Overflow saturates at the last day and never comes with a reject flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |-> (cur_day == 5'd31 && cur_month == MON_DEC
			&& cur_year == YEAR_W'(MAX_YEAR)
			&& !day_rejected && !month_rejected && !year_rejected))
		else $error("overflow result not saturated or mixed with reject flags");

endmodule

bind gregorian_date_unit gdu_checker u_gdu_checker (.*);

### sim/gdu_tb_pkg.sv
// Request codes and result record shared by the date unit testbench and its checker.
`timescale 1ns / 1ps

package gdu_tb_pkg;

	import gdu_pkg::*;

	// Operation carried by a request.
	typedef enum logic {
		OP_SET = 1'b0,
		OP_ADD = 1'b1
	} date_op_t;

	// One result as it leaves the unit.
	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic [WDAY_W-1:0]  wday;
		logic               day_rej;
		logic               month_rej;
		logic               year_rej;
		logic               ovf;
	} date_result_t;

endpackage

### sim/gregorian_date_unit_checker.sv
// Checker for the date unit: tracks the calendar on accepted requests and compares results.
`timescale 1ns / 1ps

module gregorian_date_unit_checker
	import gdu_pkg::*;
	import gdu_tb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               opcode,
	input  logic [DAY_W-1:0]   new_day,
	input  logic [MONTH_W-1:0] new_month,
	input  logic [YEAR_W-1:0]  new_year,
	input  logic [ADD_W-1:0]   days_to_add,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [DAY_W-1:0]   cur_day,
	input  logic [MONTH_W-1:0] cur_month,
	input  logic [YEAR_W-1:0]  cur_year,
	input  logic [WDAY_W-1:0]  weekday,
	input  logic               day_rejected,
	input  logic               month_rejected,
	input  logic               year_rejected,
	input  logic               overflow,
	output int unsigned        errors,
	output int unsigned        pending,
	output int unsigned        results_seen,
	output int unsigned        saturations,
	output int unsigned        rejections
);

	localparam int unsigned MAX_REPORTS = 10;

	// Calendar as the unit should hold it.
	int cal_day;
	int cal_month;
	int cal_year;

	// Results still owed by the unit, oldest first.
	date_result_t owed_dates[$];

	int unsigned reports;

	// Gregorian leap year rule.
	function automatic bit leap_year(input int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	// Number of days in month m of year y.
	function automatic int days_in_month(input int m, input int y);
		case (m)
			2:           return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	// Day of the week, Sunday being 0, with the year counted from March.
	function automatic int day_of_week(input int d, input int m, input int y);
		int a;
		int yy;
		int mm;
		a  = (14 - m) / 12;
		yy = y - a;
		mm = m + 12 * a - 2;
		return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
	endfunction

	// Apply one request to the tracked calendar and return the result it should give.
	function automatic date_result_t apply_date_request(input date_op_t op, input int nd,
			input int nm, input int ny, input int n);
		date_result_t r;
		int d;
		int m;
		int y;
		r = '0;
		if (op == OP_SET) begin
			// Month and year are judged alone; the day against what they leave behind.
			if (nm >= 1 && nm <= 12) cal_month = nm;
			else r.month_rej = 1'b1;
			if (ny >= MIN_YEAR && ny <= MAX_YEAR) cal_year = ny;
			else r.year_rej = 1'b1;
			if (nd >= 1 && nd <= days_in_month(cal_month, cal_year)) cal_day = nd;
			else r.day_rej = 1'b1;
		end else begin
			// Walk month by month, clamping at the last day of the last year.
			d = cal_day + n;
			m = cal_month;
			y = cal_year;
			while (!r.ovf && d > days_in_month(m, y)) begin
				d = d - days_in_month(m, y);
				m++;
				if (m > 12) begin
					m = 1;
					y++;
					if (y > MAX_YEAR) begin
						d = 31;
						m = 12;
						y = MAX_YEAR;
						r.ovf = 1'b1;
					end
				end
			end
			cal_day   = d;
			cal_month = m;
			cal_year  = y;
		end
		r.day   = DAY_W'(cal_day);
		r.month = MONTH_W'(cal_month);
		r.year  = YEAR_W'(cal_year);
		r.wday  = WDAY_W'(day_of_week(cal_day, cal_month, cal_year));
		return r;
	endfunction

	// Predict on each accepted request and compare each accepted result.
	always @(posedge clk or negedge arst_n) begin
		date_result_t want;
		date_result_t got;
		if (!arst_n) begin
			cal_day      = RESET_DAY;
			cal_month    = RESET_MONTH;
			cal_year     = RESET_YEAR;
			owed_dates.delete();
			errors       = 0;
			pending      = 0;
			reports      = 0;
			results_seen = 0;
			saturations  = 0;
			rejections   = 0;
		end else begin
			if (in_valid && in_ready) begin
				want = apply_date_request(date_op_t'(opcode), int'(new_day), int'(new_month),
					int'(new_year), int'(days_to_add));
				if (want.ovf) saturations++;
				if (want.day_rej || want.month_rej || want.year_rej) rejections++;
				owed_dates.push_back(want);
			end
			if (out_valid && out_ready) begin
				results_seen++;
				got = {cur_day, cur_month, cur_year, weekday, day_rejected, month_rejected,
					year_rejected, overflow};
				if (owed_dates.size() == 0) begin
					errors++;
					if (reports < MAX_REPORTS) begin
						reports++;
						$display("[%0t] result %0d arrived with no request outstanding",
							$realtime, results_seen);
					end
				end else begin
					want = owed_dates.pop_front();
					if (got.day !== want.day || got.month !== want.month ||
							got.year !== want.year || got.wday !== want.wday ||
							got.day_rej !== want.day_rej || got.month_rej !== want.month_rej ||
							got.year_rej !== want.year_rej || got.ovf !== want.ovf) begin
						errors++;
						if (reports < MAX_REPORTS) begin
							reports++;
							$display("[%0t] result %0d: expected %0d/%0d/%0d wd %0d rej %b%b%b ovf %b",
								$realtime, results_seen, want.day, want.month, want.year,
								want.wday, want.day_rej, want.month_rej, want.year_rej, want.ovf);
							$display("    got %0d/%0d/%0d wd %0d rej %b%b%b ovf %b",
								got.day, got.month, got.year, got.wday, got.day_rej,
								got.month_rej, got.year_rej, got.ovf);
						end
					end
				end
			end
			pending = owed_dates.size();
		end
	end

endmodule

### sim/gregorian_date_unit_tb.sv
// Top of the date unit testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module gregorian_date_unit_tb;

	import gdu_pkg::*;
	import gdu_tb_pkg::*;

	localparam int unsigned RANDOM_ITEMS  = 245;
	localparam int unsigned DRAIN_AT      = 120;
	localparam int unsigned LONG_HOLD     = 300;
	localparam int unsigned HOLD_AFTER    = 60;
	localparam int unsigned SETTLE_CYCLES = 40;
	// Worst case is roughly 270 requests, each with the longest walk and the longest
	// gap on each side; the limit leaves about three times that.
	localparam int unsigned RUN_LIMIT     = 2_000_000;

	logic               clk;
	logic               arst_n         = 1'b0;
	logic               in_valid       = 1'b0;
	logic               in_ready;
	logic               opcode         = 1'b0;
	logic [DAY_W-1:0]   new_day        = '0;
	logic [MONTH_W-1:0] new_month      = '0;
	logic [YEAR_W-1:0]  new_year       = '0;
	logic [ADD_W-1:0]   days_to_add    = '0;
	logic               out_valid;
	logic               out_ready      = 1'b0;
	logic [DAY_W-1:0]   cur_day;
	logic [MONTH_W-1:0] cur_month;
	logic [YEAR_W-1:0]  cur_year;
	logic [WDAY_W-1:0]  weekday;
	logic               day_rejected;
	logic               month_rejected;
	logic               year_rejected;
	logic               overflow;

	int unsigned errors;
	int unsigned pending;
	int unsigned results_seen;
	int unsigned saturations;
	int unsigned rejections;

	int unsigned set_count = 0;
	int unsigned add_count = 0;
	bit          burst_mode = 1'b0;

	gregorian_date_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.new_day        (new_day),
		.new_month      (new_month),
		.new_year       (new_year),
		.days_to_add    (days_to_add),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cur_day        (cur_day),
		.cur_month      (cur_month),
		.cur_year       (cur_year),
		.weekday        (weekday),
		.day_rejected   (day_rejected),
		.month_rejected (month_rejected),
		.year_rejected  (year_rejected),
		.overflow       (overflow)
	);

	gregorian_date_unit_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.new_day        (new_day),
		.new_month      (new_month),
		.new_year       (new_year),
		.days_to_add    (days_to_add),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cur_day        (cur_day),
		.cur_month      (cur_month),
		.cur_year       (cur_year),
		.weekday        (weekday),
		.day_rejected   (day_rejected),
		.month_rejected (month_rejected),
		.year_rejected  (year_rejected),
		.overflow       (overflow),
		.errors         (errors),
		.pending        (pending),
		.results_seen   (results_seen),
		.saturations    (saturations),
		.rejections     (rejections)
	);

	// 250 MHz clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long; none at all during bursts.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (burst_mode) return 0;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	// Offer one request after a random gap and hold it until the unit takes it.
	// Called and left at a falling edge.
	task automatic send_request(input date_op_t op, input int unsigned d, input int unsigned m,
			input int unsigned y, input int unsigned n);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		new_day     <= d[DAY_W-1:0];
		new_month   <= m[MONTH_W-1:0];
		new_year    <= y[YEAR_W-1:0];
		days_to_add <= n[ADD_W-1:0];
		if (op == OP_SET) set_count++;
		else add_count++;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Stop offering and wait until every outstanding result has been taken.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// Result side: random back-pressure, with one long hold once traffic is flowing.
	initial begin : result_sink
		int unsigned idle;
		bit          held;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			idle = pick_gap();
			if (idle > 0) begin
				out_ready <= 1'b0;
				repeat (idle) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Guard against a hung unit.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding", cycles, pending);
		$display("DONE: errors detected");
		$finish;
	end

	// Request stream: directed corners, then random traffic, then the verdict.
	initial begin : stimulus
		int unsigned i;
		int unsigned r;
		int unsigned y;
		int unsigned n;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset date, leap days and the century rule.
		send_request(OP_ADD, 0, 0, 0, 0);
		send_request(OP_SET, 29, 2, 2000, 0);
		send_request(OP_SET, 29, 2, 1900, 0);
		send_request(OP_ADD, 0, 0, 0, 0);
		send_request(OP_SET, 29, 2, 2100, 0);
		send_request(OP_SET, 29, 2, 2004, 0);
		// A zero day leaves 31 February, which an add of nothing then normalises.
		send_request(OP_SET, 31, 1, 2001, 0);
		send_request(OP_SET, 0, 2, 2001, 0);
		send_request(OP_ADD, 0, 0, 0, 0);
		send_request(OP_SET, 31, 4, 2000, 0);
		// Month and year just out of range, then every field at both ends of its width.
		send_request(OP_SET, 15, 13, 1899, 0);
		send_request(OP_SET, 31, 15, 16383, 65535);
		send_request(OP_SET, 0, 0, 0, 0);
		// Longest add from the first valid year, and a year wrap.
		send_request(OP_SET, 1, 1, 1900, 0);
		send_request(OP_ADD, 0, 0, 0, 65535);
		send_request(OP_SET, 31, 12, 1999, 0);
		send_request(OP_ADD, 31, 15, 16383, 1);
		// Landing exactly on the last day, then stepping past it.
		send_request(OP_SET, 1, 1, 9999, 0);
		send_request(OP_ADD, 0, 0, 0, 364);
		send_request(OP_ADD, 0, 0, 0, 0);
		send_request(OP_ADD, 0, 0, 0, 1);
		send_request(OP_SET, 31, 12, 9998, 0);
		send_request(OP_ADD, 0, 0, 0, 65535);
		send_request(OP_SET, 30, 2, 2000, 0);
		send_request(OP_SET, 31, 12, 10000, 0);

		// Random traffic: mostly valid sets and adds, some raw noise.
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			burst_mode = (i % 40) >= 28;
			if (i == DRAIN_AT) wait_for_results();
			r = $urandom_range(0, 99);
			if (r < 50) begin
				y = $urandom_range(0, 9);
				if (y == 0) y = $urandom_range(9950, MAX_YEAR);
				else if (y == 1) y = $urandom_range(MIN_YEAR, MIN_YEAR + 10);
				else y = $urandom_range(MIN_YEAR, MAX_YEAR);
				send_request(OP_SET, $urandom_range(1, 31), $urandom_range(1, 12), y,
					$urandom_range(0, 65535));
			end else if (r < 85) begin
				n = $urandom_range(0, 99);
				if (n < 70) n = $urandom_range(0, 400);
				else if (n < 90) n = $urandom_range(0, 4000);
				else n = $urandom_range(0, 65535);
				send_request(OP_ADD, $urandom_range(0, 31), $urandom_range(0, 15),
					$urandom_range(0, 16383), n);
			end else begin
				send_request(OP_SET, $urandom_range(0, 31), $urandom_range(0, 15),
					$urandom_range(0, 16383), $urandom_range(0, 65535));
			end
		end
		burst_mode = 1'b0;

		// Let the last results come out, then watch a little longer for strays.
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d set, %0d add), took %0d results.",
			set_count + add_count, set_count, add_count, results_seen);
		$display("Saturating adds: %0d; sets with a rejected field: %0d; mismatches: %0d.",
			saturations, rejections, errors);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### sim.f
rtl/gdu_pkg.sv
rtl/gdu_ctrl.sv
rtl/gdu_dpath.sv
rtl/gregorian_date_unit.sv
rtl/gdu_checker.sv
sim/gdu_tb_pkg.sv
sim/gregorian_date_unit_checker.sv
sim/gregorian_date_unit_tb.sv
